// ===== hdl/enfa_pkg.sv =====
package enfa_pkg;

    // Input command codes
    localparam logic [1:0] CMD_WR_EPS = 2'd0;
    localparam logic [1:0] CMD_WR_SYM = 2'd1;
    localparam logic [1:0] CMD_QUERY  = 2'd2;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W  = 4;
    localparam int unsigned CFG_DATA_W = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_STATE_COUNT  = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SYMBOL_COUNT = 4'd1;

    // Widths of the item and result fields
    localparam int unsigned SET_W = 16;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_CLO,
        S_REACH,
        S_TRANS,
        S_FINISH
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic load_item;
        logic eps_wr;
        logic sym_wr;
        logic clo_init;
        logic clo_step;
        logic save_clo;
        logic sym_issue;
        logic trans_init;
        logic out_load;
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic [1:0] command;
        logic       err;
        logic       pend_empty;
        logic       rd_live;
        logic       out_free;
    } t_dp_status;

endpackage

// ===== hdl/enfa_ctrl.sv =====
module enfa_ctrl
    import enfa_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  t_dp_status i_sts,
    output t_dp_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load_item = 1'b1;
                    n_state         = S_DECODE;
                end
            end
            S_DECODE: begin
                case (i_sts.command)
                    CMD_WR_EPS: begin
                        o_cmd.eps_wr = 1'b1;
                        n_state      = S_IDLE;
                    end
                    CMD_WR_SYM: begin
                        o_cmd.sym_wr = 1'b1;
                        n_state      = S_IDLE;
                    end
                    CMD_QUERY: begin
                        if (i_sts.err) begin
                            n_state = S_FINISH;
                        end else begin
                            o_cmd.clo_init = 1'b1;
                            n_state        = S_CLO;
                        end
                    end
                    default: begin
                        n_state = S_IDLE;
                    end
                endcase
            end
            // expand one pending state per cycle until the closure settles
            S_CLO: begin
                if (i_sts.pend_empty) begin
                    o_cmd.save_clo = 1'b1;
                    n_state        = S_REACH;
                end else begin
                    o_cmd.clo_step = 1'b1;
                end
            end
            // one symbol-row read per closure member, then drain the last read
            S_REACH: begin
                if (!i_sts.pend_empty) begin
                    o_cmd.sym_issue = 1'b1;
                end else if (!i_sts.rd_live) begin
                    o_cmd.trans_init = 1'b1;
                    n_state          = S_TRANS;
                end
            end
            S_TRANS: begin
                if (i_sts.pend_empty) begin
                    n_state = S_FINISH;
                end else begin
                    o_cmd.clo_step = 1'b1;
                end
            end
            S_FINISH: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// ===== hdl/enfa_datapath.sv =====
module enfa_datapath
    import enfa_pkg::*;
#(
    parameter int MAX_STATES  = 16,
    parameter int MAX_SYMBOLS = 4
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_dp_cmd               i_cmd,
    output t_dp_status            o_sts,
    input  logic [1:0]            i_command,
    input  logic [3:0]            i_state_index,
    input  logic [1:0]            i_symbol_index,
    input  logic [SET_W-1:0]      i_row_set,
    input  logic                  i_cfg_valid,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic                  o_status,
    output logic [SET_W-1:0]      o_closure_set,
    output logic [SET_W-1:0]      o_transition_set
);

    // Only 16 states and 4 symbols are addressable by the item fields
    localparam int RW    = (MAX_STATES < 16) ? MAX_STATES : 16;
    localparam int NSY   = (MAX_SYMBOLS < 4) ? MAX_SYMBOLS : 4;
    localparam int IW    = $clog2(RW);
    localparam int DEPTH = RW * NSY;
    localparam int AW    = $clog2(DEPTH);

    // Configuration
    logic [4:0]          r_state_count;
    logic [2:0]          r_symbol_count;

    // Latched item
    logic [1:0]          r_cmd;
    logic [3:0]          r_q;
    logic [1:0]          r_a;
    logic [RW-1:0]       r_row;

    // Epsilon rows, reset to empty sets
    logic [RW-1:0]       r_eps [RW];

    // Set registers
    logic [RW-1:0]       r_cur,   n_cur;
    logic [RW-1:0]       r_pend,  n_pend;
    logic [RW-1:0]       r_clo,   n_clo;
    logic [RW-1:0]       r_reach, n_reach;

    // Symbol-row memory with per-entry valid bits
    logic [RW-1:0]       r_sym_mem [DEPTH];
    logic [DEPTH-1:0]    r_sym_vld;
    logic [RW-1:0]       r_rd_data;
    logic                r_rd_hit;
    logic                r_rd_live;

    // Result register
    logic                r_out_valid;
    logic                r_out_status;
    logic [RW-1:0]       r_out_clo;
    logic [RW-1:0]       r_out_trans;

    logic [RW-1:0]       mask;
    logic                q_ok;
    logic                a_ok;
    logic [RW-1:0]       pick_oh;
    logic [IW-1:0]       pick_idx;
    logic [RW-1:0]       eps_row;
    logic [RW-1:0]       rd_row;
    logic [AW-1:0]       rd_addr;
    logic [AW-1:0]       wr_addr;

    // Index checks and the in-use state mask
    always_comb begin
        q_ok = (5'(r_q) < r_state_count) && (32'(r_q) < 32'(MAX_STATES));
        a_ok = (3'(r_a) < r_symbol_count) && (32'(r_a) < 32'(MAX_SYMBOLS));
        for (int j = 0; j < RW; j++) begin
            mask[j] = (5'(j) < r_state_count);
        end
    end

    // Lowest pending state and its epsilon row
    always_comb begin
        pick_oh  = r_pend & (~r_pend + RW'(1));
        pick_idx = '0;
        eps_row  = '0;
        for (int j = 0; j < RW; j++) begin
            if (pick_oh[j]) begin
                pick_idx = pick_idx | IW'(j);
                eps_row  = eps_row | r_eps[j];
            end
        end
    end

    assign rd_addr = AW'(32'(pick_idx) * NSY + 32'(r_a));
    assign wr_addr = AW'(32'(r_q[IW-1:0]) * NSY + 32'(r_a));
    assign rd_row  = r_rd_hit ? r_rd_data : '0;

    // Set datapath
    always_comb begin
        n_cur   = r_cur;
        n_pend  = r_pend;
        n_clo   = r_clo;
        n_reach = r_reach;
        if (i_cmd.clo_init) begin
            n_cur  = RW'(1) << r_q[IW-1:0];
            n_pend = RW'(1) << r_q[IW-1:0];
        end
        if (i_cmd.clo_step) begin
            n_cur  = r_cur | (eps_row & mask);
            n_pend = (r_pend & ~pick_oh) | (eps_row & mask & ~r_cur);
        end
        if (i_cmd.save_clo) begin
            n_clo   = r_cur;
            n_pend  = r_cur;
            n_reach = '0;
        end
        if (i_cmd.sym_issue) begin
            n_pend = r_pend & ~pick_oh;
        end
        if (r_rd_live) begin
            n_reach = r_reach | (rd_row & mask);
        end
        if (i_cmd.trans_init) begin
            n_cur  = r_reach;
            n_pend = r_reach;
        end
    end

    // Control and table registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state_count  <= 5'd16;
            r_symbol_count <= 3'd4;
            r_sym_vld      <= '0;
            r_rd_live      <= 1'b0;
            r_out_valid    <= 1'b0;
            for (int j = 0; j < RW; j++) begin
                r_eps[j] <= '0;
            end
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_STATE_COUNT:  r_state_count  <= i_cfg_data[4:0];
                    CFG_SYMBOL_COUNT: r_symbol_count <= i_cfg_data[2:0];
                    default: ;
                endcase
            end
            if (i_cmd.eps_wr && q_ok) begin
                r_eps[r_q[IW-1:0]] <= r_row;
            end
            if (i_cmd.sym_wr && q_ok && a_ok) begin
                r_sym_vld[wr_addr] <= 1'b1;
            end
            r_rd_live <= i_cmd.sym_issue;
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_cmd <= i_command;
            r_q   <= i_state_index;
            r_a   <= i_symbol_index;
            r_row <= i_row_set[RW-1:0];
        end
        r_cur   <= n_cur;
        r_pend  <= n_pend;
        r_clo   <= n_clo;
        r_reach <= n_reach;
        if (i_cmd.out_load) begin
            r_out_status <= !(q_ok && a_ok);
            r_out_clo    <= (q_ok && a_ok) ? r_clo : '0;
            r_out_trans  <= (q_ok && a_ok) ? r_cur : '0;
        end
    end

    // Symbol-row memory
    always_ff @(posedge i_clk) begin
        if (i_cmd.sym_wr && q_ok && a_ok) begin
            r_sym_mem[wr_addr] <= r_row;
        end
        r_rd_data <= r_sym_mem[rd_addr];
        r_rd_hit  <= r_sym_vld[rd_addr];
    end

    // Status to the controller
    always_comb begin
        o_sts.command    = r_cmd;
        o_sts.err        = !(q_ok && a_ok);
        o_sts.pend_empty = (r_pend == '0);
        o_sts.rd_live    = r_rd_live;
        o_sts.out_free   = !r_out_valid || i_out_ready;
    end

    assign o_out_valid      = r_out_valid;
    assign o_status         = r_out_status;
    assign o_closure_set    = SET_W'(r_out_clo);
    assign o_transition_set = SET_W'(r_out_trans);

endmodule

// ===== hdl/epsilon_nfa_transition_engine_unit.sv =====
// A write is accepted in idle and applied to its table in the decode state. A query
// finds E(q), the closure, and then T, the transition set: the closure unit expands
// pending states one at a time and one symbol-row memory read is issued per closure
// member. One item at a time.
// Synchronous active-low reset: tables cleared to empty sets, state_count 16,
// symbol_count 4, no result pending.
module epsilon_nfa_transition_engine_unit
    import enfa_pkg::*;
#(
    parameter int MAX_STATES  = 16,
    parameter int MAX_SYMBOLS = 4
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [1:0]            i_command,
    input  logic [3:0]            i_state_index,
    input  logic [1:0]            i_symbol_index,
    input  logic [SET_W-1:0]      i_row_set,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic                  o_status,
    output logic [SET_W-1:0]      o_closure_set,
    output logic [SET_W-1:0]      o_transition_set,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_dp_cmd    dp_cmd;
    t_dp_status dp_sts;

    // Configuration writes always taken
    assign o_cfg_ready = 1'b1;

    // Sequencer
    enfa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (dp_sts),
        .o_cmd      (dp_cmd)
    );

    // Tables, set registers and result register
    enfa_datapath #(
        .MAX_STATES  (MAX_STATES),
        .MAX_SYMBOLS (MAX_SYMBOLS)
    ) u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (dp_cmd),
        .o_sts            (dp_sts),
        .i_command        (i_command),
        .i_state_index    (i_state_index),
        .i_symbol_index   (i_symbol_index),
        .i_row_set        (i_row_set),
        .i_cfg_valid      (i_cfg_valid),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_status         (o_status),
        .o_closure_set    (o_closure_set),
        .o_transition_set (o_transition_set)
    );

endmodule
